FILE: hw/rtl/isl_pkg.sv
// Shared types and codes for the indexed shift list.
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

	// Field widths of the stream words
	localparam int CMD_W = 3;
	localparam int IDX_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_GAP   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT,
		S_DRAIN,
		S_GET_RD,
		S_COMMIT
	} state_t;

	// One accepted command word
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] item_index;
		logic [VAL_W-1:0] item_value;
	} req_t;

	// One result word
	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] entry_count;
		logic             is_full;
		logic             is_empty;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the incoming command
		logic init;    // set the memory pointer to its start
		logic rd;      // read the memory at the pointer and advance it
		logic shift;   // the read feeds a move of one entry
		logic commit;  // update the count and memory, emit the result
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic need_shift;
		logic get_ok;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/indexed_shift_list.sv
// Top level of the indexed shift list: stream ports around sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to CAPACITY words of DATA_WIDTH bits, driven by
// one command word at a time: push, pop, insert at an index, remove at an index
// and get at an index. Each command word yields exactly one result word with a
// status (ok, index out of range, list full, not contiguous), the value read by
// a successful get (zero otherwise), the count after the command and the full
// and empty flags. A rejected command leaves the list unchanged; pop on an
// empty list and unused command codes report ok and change nothing. Entries
// live in a single-port-write memory, so insert and remove move the later
// entries one per cycle. A command passes from acceptance through decode, then
// the shift walk and its drain for an insert or remove that moves entries, or
// the memory read for a get, to commit, which waits until the result register
// is free. The block takes one command at a time, and a new command can be
// accepted once the previous result is registered, even while that result
// still waits on m_tready. Entry contents are not cleared by reset; count is.
module indexed_shift_list #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // item_index[5:0], item_value[37:6], zero[39:38]
	input  wire  [2:0]  s_tuser,   // cmd[2:0]

	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // read_value[31:0], entry_count[38:32], is_full[39],
	                               // is_empty[40], zero[47:41]
	output logic [1:0]  m_tuser    // status[1:0]
);

	isl_pkg::req_t     req;
	isl_pkg::res_t     res;
	isl_pkg::dp_ctl_t  ctl;
	isl_pkg::dp_stat_t stat;

	// Unpack the command word
	assign req.cmd        = s_tuser;
	assign req.item_index = s_tdata[5:0];
	assign req.item_value = s_tdata[37:6];

	// Sequencer: accept, check, walk the shift, hold until the result slot frees
	isl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Datapath: entry memory, count, pointer and result register
	isl_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.stat      (stat),
		.res       (res),
		.res_valid (m_tvalid),
		.res_ready (m_tready)
	);

	// Pack the result word, zero fill to whole bytes
	assign m_tdata = {7'b0, res.is_empty, res.is_full, res.entry_count, res.read_value};
	assign m_tuser = res.status;

endmodule

`default_nettype wire

FILE: hw/rtl/isl_ctrl.sv
// Command sequencer of the indexed shift list.
`timescale 1ns / 1ps
`default_nettype none

module isl_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  isl_pkg::dp_stat_t stat,
	output isl_pkg::dp_ctl_t  ctl
);

	isl_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isl_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			isl_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load  = 1'b1;
					state_nxt = isl_pkg::S_DECODE;
				end
			end
			isl_pkg::S_DECODE: begin
				if (stat.need_shift) begin
					ctl.init  = 1'b1;
					state_nxt = isl_pkg::S_SHIFT;
				end else if (stat.get_ok) begin
					ctl.init  = 1'b1;
					state_nxt = isl_pkg::S_GET_RD;
				end else begin
					state_nxt = isl_pkg::S_COMMIT;
				end
			end
			isl_pkg::S_SHIFT: begin
				ctl.rd    = 1'b1;
				ctl.shift = 1'b1;
				if (stat.last) begin
					state_nxt = isl_pkg::S_DRAIN;
				end
			end
			// last moved entry is written back here
			isl_pkg::S_DRAIN: begin
				state_nxt = isl_pkg::S_COMMIT;
			end
			isl_pkg::S_GET_RD: begin
				ctl.rd    = 1'b1;
				state_nxt = isl_pkg::S_COMMIT;
			end
			isl_pkg::S_COMMIT: begin
				if (stat.out_free) begin
					ctl.commit = 1'b1;
					state_nxt  = isl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = isl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/isl_dp.sv
// Entry memory, count, shift pointer and result register of the indexed shift list.
`timescale 1ns / 1ps
`default_nettype none

module isl_dp #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  isl_pkg::req_t     req,
	input  isl_pkg::dp_ctl_t  ctl,
	output isl_pkg::dp_stat_t stat,
	output isl_pkg::res_t     res,
	output logic              res_valid,
	input  wire               res_ready
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int IW    = isl_pkg::IDX_W;
	localparam int XW    = ((CW > IW) ? CW : IW) + 1;
	localparam int VW    = isl_pkg::VAL_W;
	localparam int CNTOW = isl_pkg::CNT_W;

	logic [isl_pkg::CMD_W-1:0] cmd_q;
	logic [IW-1:0]             idx_q;
	logic [DATA_WIDTH-1:0]     val_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             ptr_q;

	logic [DATA_WIDTH-1:0]     mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0]     rd_data_s1;
	logic [AW-1:0]             rd_addr_s1;
	logic                      wb_s1;

	isl_pkg::res_t             res_q;
	logic                      res_vld_q;

	logic [XW-1:0]             idx_x;
	logic [XW-1:0]             cnt_x;
	logic [XW-1:0]             cnt_m1_x;
	logic [XW-1:0]             idx_p1_x;
	logic                      list_full;
	logic [isl_pkg::ST_W-1:0]  st;
	logic                      ok;
	logic                      shift_up;
	logic [AW-1:0]             start_ptr;
	logic [AW-1:0]             end_ptr;
	logic [CW-1:0]             cnt_nxt;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [DATA_WIDTH-1:0]     wr_data;

	assign idx_x     = XW'(idx_q);
	assign cnt_x     = XW'(count_q);
	assign cnt_m1_x  = cnt_x - XW'(1);
	assign idx_p1_x  = idx_x + XW'(1);
	assign list_full = (count_q == CW'(CAPACITY));
	assign shift_up  = (cmd_q == isl_pkg::CMD_INSERT);

	// Command checks in priority order
	always_comb begin
		st = isl_pkg::ST_OK;
		unique case (cmd_q) inside
			isl_pkg::CMD_PUSH: begin
				if (list_full) begin
					st = isl_pkg::ST_FULL;
				end
			end
			isl_pkg::CMD_INSERT: begin
				if (idx_x >= XW'(CAPACITY)) begin
					st = isl_pkg::ST_RANGE;
				end else if (list_full) begin
					st = isl_pkg::ST_FULL;
				end else if (idx_x > cnt_x) begin
					st = isl_pkg::ST_GAP;
				end
			end
			isl_pkg::CMD_REMOVE, isl_pkg::CMD_GET: begin
				if (idx_x >= cnt_x) begin
					st = isl_pkg::ST_RANGE;
				end
			end
			default: begin
				st = isl_pkg::ST_OK;
			end
		endcase
	end

	assign ok = (st == isl_pkg::ST_OK);

	assign stat.need_shift = ok && (
		(shift_up && (idx_x < cnt_x)) ||
		((cmd_q == isl_pkg::CMD_REMOVE) && (idx_p1_x < cnt_x)));
	assign stat.get_ok   = ok && (cmd_q == isl_pkg::CMD_GET);
	assign stat.last     = (ptr_q == end_ptr);
	assign stat.out_free = !res_vld_q || res_ready;

	// Insert walks down from the top entry, remove walks up from idx+1
	always_comb begin
		if (cmd_q == isl_pkg::CMD_GET) begin
			start_ptr = idx_x[AW-1:0];
		end else if (shift_up) begin
			start_ptr = cnt_m1_x[AW-1:0];
		end else begin
			start_ptr = idx_p1_x[AW-1:0];
		end
		end_ptr = shift_up ? idx_x[AW-1:0] : cnt_m1_x[AW-1:0];
	end

	always_comb begin
		cnt_nxt = count_q;
		unique case (cmd_q) inside
			isl_pkg::CMD_PUSH, isl_pkg::CMD_INSERT: begin
				if (ok) begin
					cnt_nxt = count_q + CW'(1);
				end
			end
			isl_pkg::CMD_POP: begin
				if (count_q != '0) begin
					cnt_nxt = count_q - CW'(1);
				end
			end
			isl_pkg::CMD_REMOVE: begin
				if (ok) begin
					cnt_nxt = count_q - CW'(1);
				end
			end
			default: begin
				cnt_nxt = count_q;
			end
		endcase
	end

	// Single write port: moved entries during a shift, the new word at commit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		if (wb_s1) begin
			wr_en   = 1'b1;
			wr_addr = shift_up ? (rd_addr_s1 + AW'(1)) : (rd_addr_s1 - AW'(1));
			wr_data = rd_data_s1;
		end else if (ctl.commit && ok &&
			((cmd_q == isl_pkg::CMD_PUSH) || shift_up)) begin
			wr_en   = 1'b1;
			wr_addr = shift_up ? idx_x[AW-1:0] : cnt_x[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_s1 <= mem_q[ptr_q];
			rd_addr_s1 <= ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.cmd;
			idx_q <= req.item_index;
			val_q <= DATA_WIDTH'(req.item_value);
		end
		if (ctl.init) begin
			ptr_q <= start_ptr;
		end else if (ctl.rd) begin
			ptr_q <= shift_up ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
		end
		if (ctl.commit) begin
			res_q.read_value  <= stat.get_ok ? VW'(rd_data_s1) : '0;
			res_q.status      <= st;
			res_q.entry_count <= CNTOW'(cnt_nxt);
			res_q.is_full     <= (cnt_nxt == CW'(CAPACITY));
			res_q.is_empty    <= (cnt_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			wb_s1     <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			wb_s1 <= ctl.rd && ctl.shift;
			if (ctl.commit) begin
				count_q   <= cnt_nxt;
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_vld_q;

endmodule

`default_nettype wire

FILE: tb/tb_indexed_shift_list.sv
// Self-checking testbench for the indexed shift list: directed and random command streams.
`timescale 1ns / 1ps

module tb_indexed_shift_list;

	localparam int CAPACITY    = 64;
	localparam int ITEM_TARGET = 1850;
	localparam int IDLE_LIMIT  = 3000;  // cycles with no word moving on either side
	localparam int DRAIN_WAIT  = 80;    // covers the longest insert, at index 0 of a nearly full list
	localparam int HOLD_AFTER  = 300;   // results seen before the long receiver hold
	localparam int HOLD_CYCLES = 400;
	localparam int CMD_BITS    = isl_pkg::CMD_W;

	// Command codes with no operation behind them
	localparam logic [CMD_BITS-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_C = 3'd7;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // item_index[5:0], item_value[37:6], zero[39:38]
	logic [2:0]  s_tuser  = '0;  // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // read_value[31:0], entry_count[38:32], is_full[39],
	                             // is_empty[40], zero[47:41]
	logic [1:0]  m_tuser;        // status[1:0]

	indexed_shift_list #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(isl_pkg::VAL_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Command words waiting to be sent, and results the list should produce
	isl_pkg::req_t pending[$];
	isl_pkg::res_t expected_results[$];

	// Shadow list: entries and fill level as the block should hold them
	logic [isl_pkg::VAL_W-1:0] list_mem [CAPACITY];
	int                        list_len = 0;

	// Fill level seen while planning stimulus, used to aim indexes
	int plan_len = 0;

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  peak_len       = 0;
	int  cmd_hits [8];
	int  status_hits [4];
	bit  in_taken       = 1'b0;

	// Apply one command to the shadow list and return the result it should give.
	function automatic isl_pkg::res_t apply_cmd(input isl_pkg::req_t w);
		isl_pkg::res_t r;
		int   k;
		int   idx;
		r = '0;
		r.status = isl_pkg::ST_OK;
		idx = int'(w.item_index);
		case (w.cmd)
			isl_pkg::CMD_PUSH: begin
				if (list_len >= CAPACITY) begin
					r.status = isl_pkg::ST_FULL;
				end else begin
					list_mem[list_len] = w.item_value;
					list_len++;
				end
			end
			isl_pkg::CMD_POP: begin
				if (list_len > 0)
					list_len--;
			end
			isl_pkg::CMD_INSERT: begin
				if (idx >= CAPACITY) begin
					r.status = isl_pkg::ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					r.status = isl_pkg::ST_FULL;
				end else if (idx > list_len) begin
					r.status = isl_pkg::ST_GAP;
				end else begin
					for (k = list_len; k > idx; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[idx] = w.item_value;
					list_len++;
				end
			end
			isl_pkg::CMD_REMOVE: begin
				if (idx >= list_len) begin
					r.status = isl_pkg::ST_RANGE;
				end else begin
					for (k = idx; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
				end
			end
			isl_pkg::CMD_GET: begin
				if (idx >= list_len)
					r.status = isl_pkg::ST_RANGE;
				else
					r.read_value = list_mem[idx];
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase
		r.entry_count = list_len[isl_pkg::CNT_W-1:0];
		r.is_full     = (list_len == CAPACITY);
		r.is_empty    = (list_len == 0);
		return r;
	endfunction

	// Queue one command word and track the fill level it leads to.
	function automatic void queue_cmd(input logic [CMD_BITS-1:0] c, input int idx,
	                                  input logic [isl_pkg::VAL_W-1:0] v);
		isl_pkg::req_t w;
		w.cmd        = c;
		w.item_index = idx[isl_pkg::IDX_W-1:0];
		w.item_value = v;
		pending.push_back(w);
		case (c)
			isl_pkg::CMD_PUSH:   if (plan_len < CAPACITY) plan_len++;
			isl_pkg::CMD_POP:    if (plan_len > 0) plan_len--;
			isl_pkg::CMD_INSERT: if (plan_len < CAPACITY && idx <= plan_len) plan_len++;
			isl_pkg::CMD_REMOVE: if (idx < plan_len) plan_len--;
			default:             ;
		endcase
	endfunction

	// Index aimed mostly at live entries, with boundaries and far misses mixed in.
	function automatic int pick_index();
		int r;
		int top;
		r   = $urandom_range(0, 9);
		top = (plan_len > CAPACITY - 1) ? CAPACITY - 1 : plan_len;
		if (r <= 6)
			return $urandom_range(0, top);
		else if (r == 7)
			return top;
		else if (r == 8)
			return CAPACITY - 1;
		return $urandom_range(0, CAPACITY - 1);
	endfunction

	function automatic logic [isl_pkg::VAL_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// One command drawn from weights that favor growth or shrinkage.
	function automatic void queue_weighted(input bit grow);
		int r;
		r = $urandom_range(0, 9);
		if (r <= 3)
			queue_cmd(grow ? isl_pkg::CMD_PUSH : isl_pkg::CMD_POP, pick_index(),
				pick_word());
		else if (r <= 6)
			queue_cmd(grow ? isl_pkg::CMD_INSERT : isl_pkg::CMD_REMOVE, pick_index(),
				pick_word());
		else if (r == 7)
			queue_cmd(isl_pkg::CMD_GET, pick_index(), pick_word());
		else if (r == 8)
			queue_cmd(grow ? isl_pkg::CMD_REMOVE : isl_pkg::CMD_PUSH, pick_index(),
				pick_word());
		else
			queue_cmd(grow ? isl_pkg::CMD_POP : isl_pkg::CMD_INSERT, pick_index(),
				pick_word());
	endfunction

	task automatic report_mismatch(input string what, input isl_pkg::res_t want,
	                               input isl_pkg::res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected value %h status %0d count %0d full %0b empty %0b",
				$realtime, what, want.read_value, want.status, want.entry_count,
				want.is_full, want.is_empty);
			$display("    got value %h status %0d count %0d full %0b empty %0b",
				got.read_value, got.status, got.entry_count, got.is_full, got.is_empty);
		end
	endtask

	// Sender: bursts of random length separated by random gaps. Hold a word until taken.
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		isl_pkg::req_t w;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending.size() > 0) begin
				w = pending.pop_front();
				s_tdata  <= {2'b00, w.item_value, w.item_index};
				s_tuser  <= w.cmd;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch between stall patterns; once, hold off long enough to back up the input.
	int rx_mode   = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit held_off  = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!held_off && results_seen >= HOLD_AFTER) begin
			held_off  = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 1) == 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Input side: predict each accepted word. Output side: check each result word.
	always @(posedge clk) begin
		isl_pkg::req_t w;
		isl_pkg::res_t got;
		isl_pkg::res_t want;
		in_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			w.cmd        = s_tuser;
			w.item_index = s_tdata[5:0];
			w.item_value = s_tdata[37:6];
			want = apply_cmd(w);
			expected_results.push_back(want);
			cmd_hits[w.cmd]++;
			status_hits[want.status]++;
			if (list_len > peak_len)
				peak_len = list_len;
		end
		if (m_tvalid && m_tready) begin
			got.read_value  = m_tdata[31:0];
			got.entry_count = m_tdata[38:32];
			got.is_full     = m_tdata[39];
			got.is_empty    = m_tdata[40];
			got.status      = m_tuser;
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result word with nothing expected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
				    got.entry_count !== want.entry_count || got.is_full !== want.is_full ||
				    got.is_empty !== want.is_empty)
					report_mismatch("result word mismatch", want, got);
			end
		end
	end

	// Watchdog: end the run if no word moves for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int phase;
		int n;
		int k;

		// Directed: empty list errors, front/middle/end inserts, boundary reads, unused codes
		queue_cmd(isl_pkg::CMD_GET, 0, '0);
		queue_cmd(isl_pkg::CMD_POP, 0, '0);
		queue_cmd(isl_pkg::CMD_REMOVE, 0, '0);
		queue_cmd(isl_pkg::CMD_INSERT, 1, 32'h0000_0001);
		queue_cmd(isl_pkg::CMD_INSERT, 63, 32'hFFFF_FFFF);
		queue_cmd(isl_pkg::CMD_PUSH, 0, 32'h0000_0000);
		queue_cmd(isl_pkg::CMD_PUSH, 63, 32'hFFFF_FFFF);
		queue_cmd(isl_pkg::CMD_INSERT, 0, 32'hA5A5_A5A5);
		queue_cmd(isl_pkg::CMD_INSERT, 3, 32'h5A5A_5A5A);
		queue_cmd(isl_pkg::CMD_INSERT, 2, 32'h1234_5678);
		queue_cmd(isl_pkg::CMD_INSERT, 6, 32'hDEAD_BEEF);
		queue_cmd(isl_pkg::CMD_GET, 0, '0);
		queue_cmd(isl_pkg::CMD_GET, 4, '1);
		queue_cmd(isl_pkg::CMD_GET, 5, '0);
		queue_cmd(isl_pkg::CMD_GET, 63, '0);
		queue_cmd(isl_pkg::CMD_REMOVE, 4, '0);
		queue_cmd(isl_pkg::CMD_REMOVE, 0, '0);
		queue_cmd(isl_pkg::CMD_REMOVE, 9, '0);
		queue_cmd(CMD_SPARE_A, 21, 32'h0F0F_0F0F);
		queue_cmd(CMD_SPARE_B, 42, 32'hF0F0_F0F0);
		queue_cmd(CMD_SPARE_C, 63, '1);
		queue_cmd(isl_pkg::CMD_GET, 1, '0);
		queue_cmd(isl_pkg::CMD_POP, 0, '0);

		// Random: fill to capacity and past it, drain to empty and past it, mixed, noise
		while (pending.size() < ITEM_TARGET) begin
			phase = $urandom_range(0, 9);
			if (phase <= 2) begin
				while (plan_len < CAPACITY)
					queue_weighted(1'b1);
				n = $urandom_range(4, 16);
				for (k = 0; k < n; k++)
					queue_weighted(1'b1);
			end else if (phase <= 4) begin
				while (plan_len > 0)
					queue_weighted(1'b0);
				n = $urandom_range(3, 8);
				for (k = 0; k < n; k++)
					queue_weighted(1'b0);
			end else if (phase <= 8) begin
				n = $urandom_range(30, 150);
				for (k = 0; k < n; k++)
					queue_cmd(CMD_BITS'($urandom_range(0, 4)), pick_index(), pick_word());
			end else begin
				n = $urandom_range(5, 20);
				for (k = 0; k < n; k++)
					queue_cmd(CMD_BITS'($urandom_range(0, 7)), $urandom_range(0, 63),
						$urandom());
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d commands: push %0d, pop %0d, insert %0d, remove %0d, get %0d",
			cmd_hits.sum(), cmd_hits[isl_pkg::CMD_PUSH], cmd_hits[isl_pkg::CMD_POP],
			cmd_hits[isl_pkg::CMD_INSERT], cmd_hits[isl_pkg::CMD_REMOVE],
			cmd_hits[isl_pkg::CMD_GET]);
		$display("Unused codes %0d; status ok %0d, range %0d, full %0d, gap %0d; peak fill %0d of %0d",
			cmd_hits[CMD_SPARE_A] + cmd_hits[CMD_SPARE_B] + cmd_hits[CMD_SPARE_C],
			status_hits[isl_pkg::ST_OK], status_hits[isl_pkg::ST_RANGE],
			status_hits[isl_pkg::ST_FULL], status_hits[isl_pkg::ST_GAP], peak_len, CAPACITY);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
